// ===== design/pid_controller_step_core_assert.svh =====
// ----------------------------------------------------------------------------
// pid_controller_step_core_assert.svh
// Assertion macros shared by the PID controller step core.
// ----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_STEP_CORE_ASSERT_SVH
`define PID_CONTROLLER_STEP_CORE_ASSERT_SVH

// Checks that the consequent holds in the cycle after the antecedent.
`define PIDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define PIDC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== design/pidc_pkg.sv =====
// ----------------------------------------------------------------------------
// pidc_pkg
// Types, constants and saturation helpers for the PID controller step core.
// ----------------------------------------------------------------------------
package pidc_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int SUM_W         = DATA_W + 2;
    localparam int IDX_W         = 4;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [DATA_W:0]   wide_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic [IDX_W-1:0]         cfg_idx_t;

    localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [IDX_W-1:0] {
        REG_GAIN_P        = 4'd0,
        REG_INTEGRAL_COEF = 4'd1,
        REG_DERIV_COEF    = 4'd2,
        REG_DERIV_POLE    = 4'd3,
        REG_INT_MAX       = 4'd4,
        REG_INT_MIN       = 4'd5,
        REG_OUT_MAX       = 4'd6,
        REG_OUT_MIN       = 4'd7
    } reg_idx_t;

    typedef struct packed {
        data_t gain_p;
        data_t integral_coef;
        data_t deriv_coef;
        data_t deriv_pole;
        data_t int_max;
        data_t int_min;
        data_t out_max;
        data_t out_min;
    } cfg_t;

    typedef struct packed {
        data_t target;
        data_t sensed;
        logic  clear_integral;
    } in_item_t;

    typedef struct packed {
        data_t drive;
        data_t integral_now;
    } out_item_t;

    function automatic data_t sat_sum(input sum_t x);
        logic fits;
        fits = (&x[SUM_W-1:DATA_W-1]) || !(|x[SUM_W-1:DATA_W-1]);
        if (fits)
            return x[DATA_W-1:0];
        else if (x[SUM_W-1])
            return DATA_MIN;
        else
            return DATA_MAX;
    endfunction

    // The upper limit is tested first; crossed limits give hi if x > hi, else lo.
    function automatic data_t clamp(input data_t x, input data_t lo, input data_t hi);
        if (x > hi)
            return hi;
        else if (x < lo)
            return lo;
        else
            return x;
    endfunction

endpackage

// ===== design/pid_controller_step_core.sv =====
// ----------------------------------------------------------------------------
// pid_controller_step_core
// Inputs are registered, then results in the output register; one transaction
// per cycle is sustained unless the output stalls. Four parallel multipliers
// and the clamp chain between the two registers set the cycle time.
// Reset clears the controller state and loads the default gains and limits.
// ----------------------------------------------------------------------------
`include "pid_controller_step_core_assert.svh"

module pid_controller_step_core
    import pidc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  cfg_idx_t          cfg_index,
    input  logic [DATA_W-1:0] cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_item_t          in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output out_item_t         out_data
);

    cfg_t      cfg;
    out_item_t result;

    logic      s1_valid_reg, s1_valid_next;
    in_item_t  s1_data_reg,  s1_data_next;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_reg,       out_next;

    logic      accept;
    logic      advance;

    pidc_cfg_regs #(.FRAC_BITS(FRAC_BITS)) u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pidc_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (s1_data_reg),
        .step   (advance),
        .result (result)
    );

    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign s1_valid_next  = accept || (s1_valid_reg && !advance);
    assign s1_data_next   = accept ? in_data : s1_data_reg;
    assign out_valid_next = advance || (out_valid_reg && out_stall);
    assign out_next       = advance ? result : out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_data_reg <= s1_data_next;
        out_reg     <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `PIDC_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_reg, "Step result was not registered.")
    `PIDC_ASSERT_NEXT(a_accept_fills_s1, accept, s1_valid_reg, "Accepted transaction was lost.")
    `PIDC_ASSERT_NEXT(a_s1_holds, s1_valid_reg && !advance, s1_valid_reg && $stable(s1_data_reg), "Waiting input changed.")
    `PIDC_ASSERT_NOW(a_no_overwrite, out_valid_reg && out_stall, !advance, "Stalled result was overwritten.")

endmodule

// ===== design/pidc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pidc_cfg_regs
// Coefficient and limit registers, written through a plain write port.
// ----------------------------------------------------------------------------
module pidc_cfg_regs
    import pidc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  cfg_idx_t          cfg_index,
    input  logic [DATA_W-1:0] cfg_data,
    output cfg_t              cfg
);

    localparam data_t GAIN_ONE = DATA_W'(1) << FRAC_BITS;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GAIN_P:        cfg_next.gain_p        = cfg_data;
                REG_INTEGRAL_COEF: cfg_next.integral_coef = cfg_data;
                REG_DERIV_COEF:    cfg_next.deriv_coef    = cfg_data;
                REG_DERIV_POLE:    cfg_next.deriv_pole    = cfg_data;
                REG_INT_MAX:       cfg_next.int_max       = cfg_data;
                REG_INT_MIN:       cfg_next.int_min       = cfg_data;
                REG_OUT_MAX:       cfg_next.out_max       = cfg_data;
                REG_OUT_MIN:       cfg_next.out_min       = cfg_data;
                default:           cfg_next               = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p        <= GAIN_ONE;
            cfg_reg.integral_coef <= '0;
            cfg_reg.deriv_coef    <= '0;
            cfg_reg.deriv_pole    <= '0;
            cfg_reg.int_max       <= DATA_MAX;
            cfg_reg.int_min       <= DATA_MIN;
            cfg_reg.out_max       <= DATA_MAX;
            cfg_reg.out_min       <= DATA_MIN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/pidc_mulq.sv =====
// ----------------------------------------------------------------------------
// pidc_mulq
// Fixed-point multiply: exact product, floor shift by the fraction width,
// saturation to the data range.
// ----------------------------------------------------------------------------
module pidc_mulq
    import pidc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  data_t a,
    input  wide_t b,
    output data_t p
);

    localparam int PW = 2 * DATA_W + 1;

    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] shifted;
    logic                 fits;

    assign prod    = $signed({{(PW-DATA_W){a[DATA_W-1]}}, a})
                   * $signed({{(PW-DATA_W-1){b[DATA_W]}}, b});
    assign shifted = prod >>> FRAC_BITS;
    assign fits    = (&shifted[PW-1:DATA_W-1]) || !(|shifted[PW-1:DATA_W-1]);

    always_comb
    begin
        if (fits)
            p = shifted[DATA_W-1:0];
        else if (shifted[PW-1])
            p = DATA_MIN;
        else
            p = DATA_MAX;
    end

endmodule

// ===== design/pidc_datapath.sv =====
// ----------------------------------------------------------------------------
// pidc_datapath
// One controller step: error, three terms, clamps, and the recurrence state.
// ----------------------------------------------------------------------------
module pidc_datapath
    import pidc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  in_item_t  item,
    input  logic      step,
    output out_item_t result
);

    data_t acc_reg,    acc_next;
    data_t err_reg,    err_next;
    data_t deriv_reg,  deriv_next;
    data_t sensed_reg, sensed_next;

    data_t err;
    wide_t err_pair;
    wide_t sensed_delta;
    data_t acc_base;
    data_t p_prop;
    data_t p_int;
    data_t p_pole;
    data_t p_delta;
    data_t integ;
    data_t deriv;
    data_t drive;

    assign err          = sat_sum(sum_t'(item.target) - sum_t'(item.sensed));
    assign err_pair     = wide_t'(err) + wide_t'(err_reg);
    assign sensed_delta = wide_t'(item.sensed) - wide_t'(sensed_reg);
    assign acc_base     = item.clear_integral ? '0 : acc_reg;

    pidc_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_prop
    (
        .a (cfg.gain_p),
        .b (wide_t'(err)),
        .p (p_prop)
    );

    pidc_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_int
    (
        .a (cfg.integral_coef),
        .b (err_pair),
        .p (p_int)
    );

    pidc_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_pole
    (
        .a (cfg.deriv_pole),
        .b (wide_t'(deriv_reg)),
        .p (p_pole)
    );

    pidc_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_delta
    (
        .a (cfg.deriv_coef),
        .b (sensed_delta),
        .p (p_delta)
    );

    assign integ = clamp(sat_sum(sum_t'(acc_base) + sum_t'(p_int)), cfg.int_min, cfg.int_max);
    assign deriv = sat_sum(sum_t'(p_pole) - sum_t'(p_delta));
    assign drive = clamp(sat_sum(sum_t'(p_prop) + sum_t'(integ) + sum_t'(deriv)),
                         cfg.out_min, cfg.out_max);

    assign result.drive        = drive;
    assign result.integral_now = integ;

    assign acc_next    = step ? integ       : acc_reg;
    assign err_next    = step ? err         : err_reg;
    assign deriv_next  = step ? deriv       : deriv_reg;
    assign sensed_next = step ? item.sensed : sensed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            err_reg    <= '0;
            deriv_reg  <= '0;
            sensed_reg <= '0;
        end
        else
        begin
            acc_reg    <= acc_next;
            err_reg    <= err_next;
            deriv_reg  <= deriv_next;
            sensed_reg <= sensed_next;
        end
    end

endmodule
